/* rtl/hfs_pkg.sv */
// ----------------------------------------------------------------------------
// hfs_pkg
// Shared types and constants of the height field bilinear sampler.
// ----------------------------------------------------------------------------
`default_nettype none

package hfs_pkg;

    // Default number of vertices on one side of the height store.
    localparam int MAX_SIDE_DEF = 256;

    // Fraction bits of the cell fraction and of the interpolation weights.
    localparam int FRAC_W   = 16;
    // Width of a weight, which can reach 1.0.
    localparam int WEIGHT_W = FRAC_W + 1;
    // Field widths.
    localparam int HEIGHT_W = 16;
    localparam int POS_W    = 24;
    localparam int CLAMP_W  = POS_W - 1;
    localparam int CELL_W   = 16;
    localparam int SIDE_W   = 9;
    localparam int LIMIT_W  = SIDE_W + CELL_W;
    localparam int VTX_W    = 8;
    localparam int RES_W    = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Reset value of the cell size register (1.0 m in Q8.8).
    localparam logic [CELL_W-1:0] CELL_SIZE_RST = 16'h0100;

    // Item function codes.
    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_WIDTH  = 2'd0,
        CFG_GRID_HEIGHT = 2'd1,
        CFG_CELL_SIZE   = 2'd2
    } hfs_cfg_e;

    // Fields of an item that ride along the divider pipeline.
    typedef struct packed {
        logic                       func;
        logic                       wr_ok;
        logic [VTX_W-1:0]           vx;
        logic [VTX_W-1:0]           vy;
        logic signed [HEIGHT_W-1:0] hv;
    } hfs_item_t;

endpackage

`default_nettype wire

/* rtl/hfs_div.sv */
// ----------------------------------------------------------------------------
// hfs_div
// Two-lane restoring divider pipeline, one quotient bit per stage. Each lane
// divides a clamped position, scaled by 2^16, by the cell size.
// ----------------------------------------------------------------------------
`default_nettype none

module hfs_div #(
    parameter int QW = $clog2(hfs_pkg::MAX_SIDE_DEF) + hfs_pkg::FRAC_W
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         en,
    input  wire logic                         in_v,
    input  wire hfs_pkg::hfs_item_t           in_item,
    input  wire logic [hfs_pkg::CLAMP_W-1:0]  in_px,
    input  wire logic [hfs_pkg::CLAMP_W-1:0]  in_py,
    input  wire logic [hfs_pkg::CELL_W-1:0]   cell_sz,
    output logic                              out_v,
    output hfs_pkg::hfs_item_t                out_item,
    output logic [QW-1:0]                     out_qx,
    output logic [QW-1:0]                     out_qy
);
    import hfs_pkg::*;

    localparam int DIVD_W = CLAMP_W + FRAC_W;

    // One restoring step: returns the quotient bit over the new remainder.
    function automatic logic [CELL_W:0] div_step(
        input logic [CELL_W-1:0] rem,
        input logic              dbit,
        input logic [CELL_W-1:0] dvs
    );
        logic [CELL_W+1:0] trial;
        logic              ge;
        logic [CELL_W-1:0] rem_n;
        trial = {1'b0, rem, dbit} - {2'b00, dvs};
        ge    = ~trial[CELL_W+1];
        rem_n = ge ? trial[CELL_W-1:0] : {rem[CELL_W-2:0], dbit};
        return {ge, rem_n};
    endfunction

    logic               v_reg  [QW];
    hfs_item_t          it_reg [QW];
    logic [CELL_W-1:0]  rx_reg [QW];
    logic [CELL_W-1:0]  ry_reg [QW];
    logic [QW-1:0]      dx_reg [QW];
    logic [QW-1:0]      dy_reg [QW];
    logic [QW-1:0]      qx_reg [QW];
    logic [QW-1:0]      qy_reg [QW];

    logic [DIVD_W-1:0] divd_x;
    logic [DIVD_W-1:0] divd_y;

    // The quotient stays below 2^QW, so the top bits start as the remainder.
    assign divd_x = {in_px, {FRAC_W{1'b0}}};
    assign divd_y = {in_py, {FRAC_W{1'b0}}};

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic              v_in;
        hfs_item_t         it_in;
        logic [CELL_W-1:0] rx_in;
        logic [CELL_W-1:0] ry_in;
        logic [QW-1:0]     dx_in;
        logic [QW-1:0]     dy_in;
        logic [QW-1:0]     qx_in;
        logic [QW-1:0]     qy_in;
        logic [CELL_W:0]   sx;
        logic [CELL_W:0]   sy;

        if (k == 0) begin : g_first
            assign v_in  = in_v;
            assign it_in = in_item;
            assign rx_in = CELL_W'(divd_x >> QW);
            assign ry_in = CELL_W'(divd_y >> QW);
            assign dx_in = QW'(divd_x);
            assign dy_in = QW'(divd_y);
            assign qx_in = '0;
            assign qy_in = '0;
        end else begin : g_next
            assign v_in  = v_reg[k-1];
            assign it_in = it_reg[k-1];
            assign rx_in = rx_reg[k-1];
            assign ry_in = ry_reg[k-1];
            assign dx_in = dx_reg[k-1];
            assign dy_in = dy_reg[k-1];
            assign qx_in = qx_reg[k-1];
            assign qy_in = qy_reg[k-1];
        end

        // Trial subtraction of the cell size on both lanes.
        assign sx = div_step(rx_in, dx_in[QW-1], cell_sz);
        assign sy = div_step(ry_in, dy_in[QW-1], cell_sz);

        // Stage valid bit.
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= v_in;
            end
        end

        // Stage payload.
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                it_reg[k] <= it_in;
                rx_reg[k] <= sx[CELL_W-1:0];
                ry_reg[k] <= sy[CELL_W-1:0];
                dx_reg[k] <= {dx_in[QW-2:0], 1'b0};
                dy_reg[k] <= {dy_in[QW-2:0], 1'b0};
                qx_reg[k] <= {qx_in[QW-2:0], sx[CELL_W]};
                qy_reg[k] <= {qy_in[QW-2:0], sy[CELL_W]};
            end
        end
    end

    assign out_v    = v_reg[QW-1];
    assign out_item = it_reg[QW-1];
    assign out_qx   = qx_reg[QW-1];
    assign out_qy   = qy_reg[QW-1];

endmodule

`default_nettype wire

/* rtl/hfs_interp.sv */
// ----------------------------------------------------------------------------
// hfs_interp
// Six-stage bilinear interpolation of four vertex heights with Q.16 weights,
// rounded to eight fraction bits.
// ----------------------------------------------------------------------------
`default_nettype none

module hfs_interp (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                en,
    input  wire logic                                in_v,
    input  wire logic signed [hfs_pkg::HEIGHT_W-1:0] h00,
    input  wire logic signed [hfs_pkg::HEIGHT_W-1:0] h10,
    input  wire logic signed [hfs_pkg::HEIGHT_W-1:0] h01,
    input  wire logic signed [hfs_pkg::HEIGHT_W-1:0] h11,
    input  wire logic [hfs_pkg::WEIGHT_W-1:0]        tx,
    input  wire logic [hfs_pkg::WEIGHT_W-1:0]        ty,
    output logic                                     out_v,
    output logic signed [hfs_pkg::RES_W-1:0]         res
);
    import hfs_pkg::*;

    localparam int DIFF_W = HEIGHT_W + 1;
    localparam int PROD_W = DIFF_W + WEIGHT_W + 1;
    localparam int ROW_W  = HEIGHT_W + FRAC_W + 1;
    localparam int DH_W   = ROW_W + 1;
    localparam int FIN_W  = DH_W + WEIGHT_W + 1;
    localparam int RND_SH = 2 * FRAC_W - 8;

    logic [5:0] v_reg;

    logic signed [DIFF_W-1:0]   d0_reg, d1_reg;
    logic signed [HEIGHT_W-1:0] a00_reg, a01_reg, b00_reg, b01_reg;
    logic [WEIGHT_W-1:0]        tx1_reg;
    logic [WEIGHT_W-1:0]        ty1_reg, ty2_reg, ty3_reg, ty4_reg;
    logic signed [PROD_W-1:0]   m0_reg, m1_reg;
    logic signed [ROW_W-1:0]    h0_reg, h1_reg, h0r_reg, h0r5_reg;
    logic signed [DH_W-1:0]     dh_reg;
    logic signed [FIN_W-1:0]    p_reg;
    logic signed [RES_W-1:0]    res_reg;

    logic signed [PROD_W-1:0] m0_next, m1_next, s0, s1;
    logic signed [FIN_W-1:0]  p_next, fin;

    // Row weights along x.
    assign m0_next = d0_reg * $signed({1'b0, tx1_reg});
    assign m1_next = d1_reg * $signed({1'b0, tx1_reg});

    // Row heights with 16 fraction bits.
    assign s0 = {{(PROD_W-HEIGHT_W-FRAC_W){b00_reg[HEIGHT_W-1]}}, b00_reg,
                 {FRAC_W{1'b0}}} + m0_reg;
    assign s1 = {{(PROD_W-HEIGHT_W-FRAC_W){b01_reg[HEIGHT_W-1]}}, b01_reg,
                 {FRAC_W{1'b0}}} + m1_reg;

    // Column weight along y.
    assign p_next = dh_reg * $signed({1'b0, ty4_reg});

    // Final sum; the rounding half was already added to the upper row.
    assign fin = {{(FIN_W-ROW_W-FRAC_W){h0r5_reg[ROW_W-1]}}, h0r5_reg,
                  {FRAC_W{1'b0}}} + p_reg;

    // Valid bits of the six stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[4:0], in_v};
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d0_reg   <= DIFF_W'(h10) - DIFF_W'(h00);
            d1_reg   <= DIFF_W'(h11) - DIFF_W'(h01);
            a00_reg  <= h00;
            a01_reg  <= h01;
            tx1_reg  <= tx;
            ty1_reg  <= ty;

            m0_reg   <= m0_next;
            m1_reg   <= m1_next;
            b00_reg  <= a00_reg;
            b01_reg  <= a01_reg;
            ty2_reg  <= ty1_reg;

            h0_reg   <= s0[ROW_W-1:0];
            h1_reg   <= s1[ROW_W-1:0];
            ty3_reg  <= ty2_reg;

            h0r_reg  <= h0_reg + ROW_W'(128);
            dh_reg   <= DH_W'(h1_reg) - DH_W'(h0_reg);
            ty4_reg  <= ty3_reg;

            p_reg    <= p_next;
            h0r5_reg <= h0r_reg;

            res_reg  <= fin[RND_SH+RES_W-1:RND_SH];
        end
    end

    assign out_v = v_reg[5];
    assign res   = res_reg;

endmodule

`default_nettype wire

/* rtl/heightfield_bilinear_sampler.sv */
// Stage order: input, clamp, divider, cell index, memory read, interpolation
// and output. Throughput: one item per cycle while the skid buffer is empty;
// write items give no result.
// Reset clears all control state; the height store stays undefined until
// written and needs no clearing pass.
// ----------------------------------------------------------------------------
// heightfield_bilinear_sampler
// Vertex height store in four parity banks with pipelined bilinear sampling.
// ----------------------------------------------------------------------------
`default_nettype none

module heightfield_bilinear_sampler #(
    parameter int MAX_SIDE = hfs_pkg::MAX_SIDE_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [hfs_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [hfs_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic                                  func,
    input  wire logic [hfs_pkg::VTX_W-1:0]             vertex_x,
    input  wire logic [hfs_pkg::VTX_W-1:0]             vertex_y,
    input  wire logic signed [hfs_pkg::HEIGHT_W-1:0]   height_value,
    input  wire logic signed [hfs_pkg::POS_W-1:0]      world_x,
    input  wire logic signed [hfs_pkg::POS_W-1:0]      world_y,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic signed [hfs_pkg::RES_W-1:0]           sampled_height,
    output logic                                       grid_ok
);
    import hfs_pkg::*;

    localparam int IDX_W      = $clog2(MAX_SIDE);
    localparam int QW         = IDX_W + FRAC_W;
    localparam int HALF_W     = (IDX_W > 1) ? IDX_W - 1 : 1;
    localparam int BANK_DEPTH = 1 << (2 * HALF_W);

    // Configuration registers.
    logic [SIDE_W-1:0] gw_reg, gh_reg;
    logic [CELL_W-1:0] cs_reg;

    // Values derived from the configuration.
    logic [SIDE_W-1:0]  wm1_reg, wm2_reg, hm1_reg, hm2_reg;
    logic [LIMIT_W-1:0] limx_reg, limy_reg;
    logic               ok_reg;

    logic en;

    // Input stage.
    logic                     s0_v_reg;
    hfs_item_t                s0_item_reg;
    logic signed [POS_W-1:0]  s0_wx_reg, s0_wy_reg;

    // Clamp stage.
    logic                     s1_v_reg;
    hfs_item_t                s1_item_reg;
    logic [CLAMP_W-1:0]       s1_px_reg, s1_py_reg;

    // Divider outputs.
    logic                     dv_v;
    hfs_item_t                dv_item;
    logic [QW-1:0]            dv_qx, dv_qy;

    // Cell index stage.
    logic                     sc_v_reg;
    hfs_item_t                sc_item_reg;
    logic [IDX_W-1:0]         sc_x0_reg, sc_y0_reg;
    logic [WEIGHT_W-1:0]      sc_tx_reg, sc_ty_reg;

    // Memory read stage.
    logic                       sm_v_reg;
    logic                       sm_xp_reg, sm_yp_reg;
    logic [WEIGHT_W-1:0]        sm_tx_reg, sm_ty_reg;
    logic signed [HEIGHT_W-1:0] rd_reg [4];

    // Interpolation output and output buffering.
    logic                       ip_v;
    logic signed [RES_W-1:0]    ip_res;
    logic                       out_v_reg, skid_v_reg;
    logic signed [RES_W-1:0]    out_h_reg, skid_h_reg;
    logic                       out_ok_reg, skid_ok_reg;

    // Clamp a Q15.8 position into [0, limit].
    function automatic logic [CLAMP_W-1:0] clamp_pos(
        input logic signed [POS_W-1:0] w,
        input logic [LIMIT_W-1:0]      lim
    );
        logic [LIMIT_W-1:0] wu;
        wu = LIMIT_W'({1'b0, w});
        if (w[POS_W-1])
            return '0;
        else if (wu > lim)
            return CLAMP_W'(lim);
        else
            return CLAMP_W'(wu);
    endfunction

    // The pipeline freezes only when the skid buffer is occupied.
    assign en        = ~skid_v_reg;
    assign in_ready  = en;
    assign cfg_ready = 1'b1;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gw_reg <= '0;
            gh_reg <= '0;
            cs_reg <= CELL_SIZE_RST;
        end
        else if (cfg_valid)
        begin
            unique case (hfs_cfg_e'(cfg_index))
                CFG_GRID_WIDTH:  gw_reg <= cfg_data[SIDE_W-1:0];
                CFG_GRID_HEIGHT: gh_reg <= cfg_data[SIDE_W-1:0];
                CFG_CELL_SIZE:   cs_reg <= cfg_data[CELL_W-1:0];
                default:         ;
            endcase
        end
    end

    // Derived configuration values, settled in the cycle after a write.
    always_ff @(posedge clk)
    begin
        wm1_reg  <= gw_reg - SIDE_W'(1);
        wm2_reg  <= gw_reg - SIDE_W'(2);
        hm1_reg  <= gh_reg - SIDE_W'(1);
        hm2_reg  <= gh_reg - SIDE_W'(2);
        limx_reg <= LIMIT_W'(gw_reg - SIDE_W'(1)) * LIMIT_W'(cs_reg);
        limy_reg <= LIMIT_W'(gh_reg - SIDE_W'(1)) * LIMIT_W'(cs_reg);
        ok_reg   <= (gw_reg >= SIDE_W'(2)) && (gh_reg >= SIDE_W'(2)) &&
                    (32'(gw_reg) <= 32'(MAX_SIDE)) &&
                    (32'(gh_reg) <= 32'(MAX_SIDE)) && (cs_reg != '0);
    end

    // Valid bits of the input, clamp, cell index and read stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_v_reg <= 1'b0;
            s1_v_reg <= 1'b0;
            sc_v_reg <= 1'b0;
            sm_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_v_reg <= in_valid;
            s1_v_reg <= s0_v_reg;
            sc_v_reg <= dv_v;
            sm_v_reg <= sc_v_reg && (sc_item_reg.func == FUNC_SAMPLE);
        end
    end

    // Payloads of the input, clamp, cell index and read stages.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_item_reg.func  <= func;
            s0_item_reg.wr_ok <= (32'(vertex_x) < 32'(MAX_SIDE)) &&
                                 (32'(vertex_y) < 32'(MAX_SIDE));
            s0_item_reg.vx    <= vertex_x;
            s0_item_reg.vy    <= vertex_y;
            s0_item_reg.hv    <= height_value;
            s0_wx_reg         <= world_x;
            s0_wy_reg         <= world_y;

            s1_item_reg <= s0_item_reg;
            s1_px_reg   <= clamp_pos(s0_wx_reg, limx_reg);
            s1_py_reg   <= clamp_pos(s0_wy_reg, limy_reg);

            // At the far edge the index holds back and the fraction is 1.0.
            sc_item_reg <= dv_item;
            if (32'(dv_qx[QW-1:FRAC_W]) >= 32'(wm1_reg))
            begin
                sc_x0_reg <= IDX_W'(wm2_reg);
                sc_tx_reg <= WEIGHT_W'(1 << FRAC_W);
            end
            else
            begin
                sc_x0_reg <= dv_qx[QW-1:FRAC_W];
                sc_tx_reg <= {1'b0, dv_qx[FRAC_W-1:0]};
            end
            if (32'(dv_qy[QW-1:FRAC_W]) >= 32'(hm1_reg))
            begin
                sc_y0_reg <= IDX_W'(hm2_reg);
                sc_ty_reg <= WEIGHT_W'(1 << FRAC_W);
            end
            else
            begin
                sc_y0_reg <= dv_qy[QW-1:FRAC_W];
                sc_ty_reg <= {1'b0, dv_qy[FRAC_W-1:0]};
            end

            sm_xp_reg <= sc_x0_reg[0];
            sm_yp_reg <= sc_y0_reg[0];
            sm_tx_reg <= sc_tx_reg;
            sm_ty_reg <= sc_ty_reg;
        end
    end

    hfs_div #(
        .QW(QW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_v     (s1_v_reg),
        .in_item  (s1_item_reg),
        .in_px    (s1_px_reg),
        .in_py    (s1_py_reg),
        .cell_sz  (cs_reg),
        .out_v    (dv_v),
        .out_item (dv_item),
        .out_qx   (dv_qx),
        .out_qy   (dv_qy)
    );

    // Bank addresses: bank {py, px} holds vertices of row parity py and
    // column parity px, so the four neighbors always fall in different banks.
    logic [IDX_W:0]         x0p1, y0p1;
    logic [HALF_W-1:0]      col_even, col_odd, row_even, row_odd;
    logic [IDX_W-1:0]       wr_x, wr_y;
    logic [2*HALF_W-1:0]    wr_addr;
    logic [1:0]             wr_bank;
    logic                   wr_go;

    assign x0p1     = (IDX_W+1)'(sc_x0_reg) + (IDX_W+1)'(1);
    assign y0p1     = (IDX_W+1)'(sc_y0_reg) + (IDX_W+1)'(1);
    assign col_even = HALF_W'(x0p1 >> 1);
    assign col_odd  = HALF_W'(sc_x0_reg >> 1);
    assign row_even = HALF_W'(y0p1 >> 1);
    assign row_odd  = HALF_W'(sc_y0_reg >> 1);

    assign wr_x    = IDX_W'(sc_item_reg.vx);
    assign wr_y    = IDX_W'(sc_item_reg.vy);
    assign wr_addr = {HALF_W'(wr_y >> 1), HALF_W'(wr_x >> 1)};
    assign wr_bank = {wr_y[0], wr_x[0]};
    assign wr_go   = en && sc_v_reg && (sc_item_reg.func == FUNC_WRITE) &&
                     sc_item_reg.wr_ok;

    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic signed [HEIGHT_W-1:0] mem [BANK_DEPTH];
        logic [2*HALF_W-1:0]        rd_addr;

        assign rd_addr = {(b / 2 == 1) ? row_odd : row_even,
                          (b % 2 == 1) ? col_odd : col_even};

        // One write port and one registered read port per bank.
        always_ff @(posedge clk)
        begin
            if (wr_go && (wr_bank == 2'(b)))
            begin
                mem[wr_addr] <= sc_item_reg.hv;
            end
            if (en)
            begin
                rd_reg[b] <= mem[rd_addr];
            end
        end
    end

    hfs_interp u_interp (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .in_v  (sm_v_reg),
        .h00   (rd_reg[{sm_yp_reg, sm_xp_reg}]),
        .h10   (rd_reg[{sm_yp_reg, ~sm_xp_reg}]),
        .h01   (rd_reg[{~sm_yp_reg, sm_xp_reg}]),
        .h11   (rd_reg[{~sm_yp_reg, ~sm_xp_reg}]),
        .tx    (sm_tx_reg),
        .ty    (sm_ty_reg),
        .out_v (ip_v),
        .res   (ip_res)
    );

    // Output register with a one-item skid buffer behind it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (!out_v_reg || out_ready)
        begin
            out_v_reg  <= skid_v_reg || (ip_v && en);
            skid_v_reg <= 1'b0;
        end
        else if (ip_v && en)
        begin
            skid_v_reg <= 1'b1;
        end
    end

    // Output and skid payloads.
    always_ff @(posedge clk)
    begin
        if (!out_v_reg || out_ready)
        begin
            if (skid_v_reg)
            begin
                out_h_reg  <= skid_h_reg;
                out_ok_reg <= skid_ok_reg;
            end
            else
            begin
                out_h_reg  <= ok_reg ? ip_res : '0;
                out_ok_reg <= ok_reg;
            end
        end
        else if (ip_v && en)
        begin
            skid_h_reg  <= ok_reg ? ip_res : '0;
            skid_ok_reg <= ok_reg;
        end
    end

    assign out_valid      = out_v_reg;
    assign sampled_height = out_h_reg;
    assign grid_ok        = out_ok_reg;

endmodule

`default_nettype wire

/* rtl/hfs_check.sv */
// ----------------------------------------------------------------------------
// hfs_check
// Port-level checks of the height field bilinear sampler, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module hfs_check (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [23:0] sampled_height,
    input wire logic        grid_ok
);

    // No result is offered while reset is held.
    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result offered during reset");

    // A result on an invalid grid is forced to zero.
    a_bad_grid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !grid_ok |-> sampled_height == 24'h000000)
        else $error("nonzero height on invalid grid");

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(sampled_height) && $stable(grid_ok))
        else $error("result changed while stalled");

    // The input only backs up behind a waiting result.
    a_in_block: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input blocked with no result waiting");

endmodule

bind heightfield_bilinear_sampler hfs_check u_hfs_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .sampled_height (sampled_height),
    .grid_ok        (grid_ok)
);

`default_nettype wire

/* tb/hfs_checker.sv */
// ----------------------------------------------------------------------------
// hfs_checker
// Watches the register, input and result channels of the height field
// sampler. It keeps its own height store and registers, predicts the result
// of each sample item, and compares the results in order.
// ----------------------------------------------------------------------------
module hfs_checker
    import hfs_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic                       func,
    input  logic [VTX_W-1:0]           vertex_x,
    input  logic [VTX_W-1:0]           vertex_y,
    input  logic signed [HEIGHT_W-1:0] height_value,
    input  logic signed [POS_W-1:0]    world_x,
    input  logic signed [POS_W-1:0]    world_y,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic signed [RES_W-1:0]    sampled_height,
    input  logic                       grid_ok,
    output int                         failures,
    output int                         pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int EXP_DEPTH = 1024;

    typedef struct {
        logic signed [RES_W-1:0] height;
        logic                    ok;
    } sample_t;

    logic signed [HEIGHT_W-1:0] heights [0:65535];
    logic [SIDE_W-1:0]          width_reg;
    logic [SIDE_W-1:0]          height_reg;
    logic [CELL_W-1:0]          cell_reg;
    sample_t                    exp_mem [EXP_DEPTH];
    int                         exp_wr;
    int                         exp_rd;
    sample_t                    exp_head;
    int                         fail_inc;

    assign pending = exp_wr - exp_rd;

    // Clamp one coordinate, then split it into cell index and Q.16 fraction.
    function automatic void split_axis(input longint pos, input longint side,
                                       output longint idx, output longint frac);
        longint limit;
        longint c;
        c = longint'(cell_reg);
        limit = (side - 1) * c;
        if (pos < 0)
            pos = 0;
        if (pos > limit)
            pos = limit;
        idx = pos / c;
        if (idx > side - 2)
            idx = side - 2;
        frac = ((pos - idx * c) << FRAC_W) / c;
    endfunction

    function automatic sample_t predict_sample(input logic signed [POS_W-1:0] wx,
                                               input logic signed [POS_W-1:0] wy);
        sample_t r;
        longint  x0, y0, tx, ty, h00, h10, h01, h11, h0, h1, h;
        if (width_reg < 2 || height_reg < 2 || width_reg > MAX_SIDE_DEF ||
            height_reg > MAX_SIDE_DEF || cell_reg == '0)
        begin
            r.height = '0;
            r.ok = 1'b0;
            return r;
        end
        split_axis(longint'(wx), longint'(width_reg), x0, tx);
        split_axis(longint'(wy), longint'(height_reg), y0, ty);
        h00 = heights[y0 * 256 + x0];
        h10 = heights[y0 * 256 + x0 + 1];
        h01 = heights[(y0 + 1) * 256 + x0];
        h11 = heights[(y0 + 1) * 256 + x0 + 1];
        h0 = (h00 <<< FRAC_W) + (h10 - h00) * tx;
        h1 = (h01 <<< FRAC_W) + (h11 - h01) * tx;
        h = (h0 <<< FRAC_W) + (h1 - h0) * ty;
        // Round to 8 fraction bits, halves going up.
        h = (h + (longint'(1) <<< 23)) >>> 24;
        r.height = h[RES_W-1:0];
        r.ok = 1'b1;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= '0;
            height_reg <= '0;
            cell_reg   <= CELL_SIZE_RST;
            failures   <= 0;
            exp_wr     <= 0;
            exp_rd     <= 0;
        end
        else
        begin
            fail_inc = 0;
            // Register writes.
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_GRID_WIDTH)
                    width_reg <= cfg_data[SIDE_W-1:0];
                else if (cfg_index == CFG_GRID_HEIGHT)
                    height_reg <= cfg_data[SIDE_W-1:0];
                else if (cfg_index == CFG_CELL_SIZE)
                    cell_reg <= cfg_data;
            end
            // Accepted input items.
            if (in_valid && in_ready)
            begin
                if (func == FUNC_WRITE)
                    heights[{vertex_y, vertex_x}] = height_value;
                else
                begin
                    exp_mem[exp_wr % EXP_DEPTH] = predict_sample(world_x, world_y);
                    exp_wr <= exp_wr + 1;
                end
            end
            // Accepted results.
            if (out_valid && out_ready)
            begin
                if (exp_wr == exp_rd)
                begin
                    $display("%0t ERROR unexpected item: sampled_height %0d grid_ok %0d",
                             $time, sampled_height, grid_ok);
                    fail_inc = fail_inc + 1;
                end
                else
                begin
                    exp_head = exp_mem[exp_rd % EXP_DEPTH];
                    exp_rd <= exp_rd + 1;
                    if (sampled_height !== exp_head.height)
                    begin
                        $display("%0t ERROR sampled_height expected %0d actual %0d",
                                 $time, exp_head.height, sampled_height);
                        fail_inc = fail_inc + 1;
                    end
                    if (grid_ok !== exp_head.ok)
                    begin
                        $display("%0t ERROR grid_ok expected %0d actual %0d",
                                 $time, exp_head.ok, grid_ok);
                        fail_inc = fail_inc + 1;
                    end
                end
            end
            failures <= failures + fail_inc;
        end
    end
endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Drives the height field sampler through directed and random item phases
// over several grid settings, and reports the verdict from the checker.
// ----------------------------------------------------------------------------
module tb_top;
    import hfs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 40;
    localparam int STALL_LIMIT  = 5000;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [CFG_DATA_W-1:0]      cfg_data = '0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic                       func = FUNC_WRITE;
    logic [VTX_W-1:0]           vertex_x = '0;
    logic [VTX_W-1:0]           vertex_y = '0;
    logic signed [HEIGHT_W-1:0] height_value = '0;
    logic signed [POS_W-1:0]    world_x = '0;
    logic signed [POS_W-1:0]    world_y = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic signed [RES_W-1:0]    sampled_height;
    logic                       grid_ok;
    int                         failures;
    int                         pending;

    int send_idle = 0;
    int recv_stall = 0;
    int stall_count = 0;
    int cur_w = 0;
    int cur_h = 0;
    int cur_c = 256;
    bit written [0:65535];

    heightfield_bilinear_sampler DUT (.*);

    hfs_checker u_checker (.*);

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Receiver side stalls at random.
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_stall);
    end

    // Watchdog on cycles without any accepted item.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) ||
                (cfg_valid && cfg_ready))
                stall_count <= 0;
            else
                stall_count <= stall_count + 1;
            if (stall_count == STALL_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // Stop sending, then wait until all results are in and the pipeline
    // has drained.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
        if (idx == CFG_GRID_WIDTH)
            cur_w = value & 9'h1FF;
        else if (idx == CFG_GRID_HEIGHT)
            cur_h = value & 9'h1FF;
        else if (idx == CFG_CELL_SIZE)
            cur_c = value & 16'hFFFF;
    endtask

    task automatic set_grid(input int w, input int h, input int c);
        write_reg(CFG_GRID_WIDTH, w);
        write_reg(CFG_GRID_HEIGHT, h);
        write_reg(CFG_CELL_SIZE, c);
    endtask

    // Present one item, with a random gap before it; valid stays high after.
    task automatic send_item(input logic f, input int vx, input int vy, input int hv,
                             input int wx, input int wy);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        func         <= f;
        vertex_x     <= vx[VTX_W-1:0];
        vertex_y     <= vy[VTX_W-1:0];
        height_value <= hv[HEIGHT_W-1:0];
        world_x      <= wx[POS_W-1:0];
        world_y      <= wy[POS_W-1:0];
        do @(posedge clk); while (!in_ready);
        if (f == FUNC_WRITE)
            written[vy * 256 + vx] = 1'b1;
    endtask

    task automatic write_vertex(input int vx, input int vy, input int hv);
        send_item(FUNC_WRITE, vx, vy, hv, $urandom, $urandom);
    endtask

    task automatic sample_at(input int wx, input int wy);
        send_item(FUNC_SAMPLE, $urandom_range(255), $urandom_range(255),
                  $urandom, wx, wy);
    endtask

    // Write every vertex of the active grid that has never been written.
    task automatic fill_grid();
        for (int y = 0; y < cur_h && y < 256; y++)
            for (int x = 0; x < cur_w && x < 256; x++)
                if (!written[y * 256 + x])
                    write_vertex(x, y, $urandom);
    endtask

    // Coordinate along one axis: mostly inside the grid, sometimes anywhere.
    function automatic int pick_pos(input int side);
        int limit;
        int r;
        limit = (side - 1) * cur_c;
        r = $urandom_range(9);
        if (r < 6)
            return $urandom_range((limit > 8388607) ? 8388607 : limit);
        else if (r == 6)
            return (r == 6 && $urandom_range(1)) ? limit : 0;
        else if (r == 7)
            return -$urandom_range(8388608);
        else
            return $urandom;
    endfunction

    task automatic random_phase(input int w, input int h, input int c, input int n);
        int in_grid;
        set_grid(w, h, c);
        in_grid = (w >= 2 && h >= 2 && w <= 256 && h <= 256 && c != 0);
        if (in_grid)
            fill_grid();
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(3) == 0)
            begin
                if (in_grid && $urandom_range(1))
                    write_vertex($urandom_range(w - 1), $urandom_range(h - 1), $urandom);
                else
                    write_vertex($urandom_range(255), $urandom_range(255), $urandom);
            end
            else
                sample_at(pick_pos(in_grid ? w : 2), pick_pos(in_grid ? h : 2));
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: grid invalid after reset, then extreme heights on a 2x2 grid.
        send_idle = 11;
        recv_stall = 56;
        sample_at(0, 0);
        sample_at(8388607, -8388608);
        set_grid(2, 2, 256);
        write_vertex(0, 0, 32767);
        write_vertex(1, 0, -32768);
        write_vertex(0, 1, -32768);
        write_vertex(1, 1, 32767);
        sample_at(0, 0);
        sample_at(256, 256);
        sample_at(128, 128);
        sample_at(255, 1);
        sample_at(256, 0);
        sample_at(-8388608, -8388608);
        sample_at(8388607, 8388607);
        write_vertex(255, 255, -1);
        // Zero cell size, oversize width and one-vertex width are invalid.
        write_reg(CFG_CELL_SIZE, 0);
        sample_at(100, 100);
        set_grid(300, 2, 256);
        sample_at(100, 100);
        set_grid(1, 2, 256);
        sample_at(100, 100);
        set_grid(2, 2, 256);
        write_reg(CFG_UNUSED, 16'hFFFF);
        sample_at(200, 50);

        // Random phases under three idling patterns.
        random_phase(5, 7, 3, 30);
        random_phase(12, 7, 65535, 30);
        random_phase(17, 3, $urandom_range(1, 65535), 30);
        send_idle = 56;
        recv_stall = 11;
        random_phase(2, 12, 1, 25);
        random_phase(511, 3, 256, 20);
        random_phase(4, 4, 0, 20);
        random_phase(9, 12, $urandom_range(1, 2000), 25);
        send_idle = 0;
        recv_stall = 0;
        random_phase(12, 4, $urandom_range(1, 65535), 30);
        random_phase(3, 5, 128, 25);
        random_phase(2, 2, 1, 25);

        in_valid <= 1'b0;
        drain();
        if (failures == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

/* filelist.f */
rtl/hfs_pkg.sv
rtl/hfs_div.sv
rtl/hfs_interp.sv
rtl/heightfield_bilinear_sampler.sv
rtl/hfs_check.sv
tb/hfs_checker.sv
tb/tb_top.sv
